@@ hdl/nearest_target_pursuit_controller_top_defines.svh @@
// Assertion macros for the pursuit controller.
// Used by the top level; no other dependencies.
`ifndef NEAREST_TARGET_PURSUIT_CONTROLLER_TOP_DEFINES_SVH
`define NEAREST_TARGET_PURSUIT_CONTROLLER_TOP_DEFINES_SVH
// assert an implication, disabled in reset
`define NTP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// assert a next-cycle implication, disabled in reset
`define NTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ hdl/ntp_pkg.sv @@
// Package for the pursuit controller: types, constants, CORDIC angle table.
// No dependencies.
`timescale 1ns / 1ps
package ntp_pkg;
   localparam int MaxTargets  = 16;
   localparam int CordicSteps = 16;
   localparam int IdxW        = $clog2(MaxTargets);
   localparam int CntW        = $clog2(MaxTargets + 1);
   localparam int StepW       = $clog2(CordicSteps + 1);
   localparam int WorkW       = 33;
   localparam int AngW        = 19;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_POSE   = 2'd2;

   localparam logic [1:0] REG_TURN_GAIN   = 2'd0;
   localparam logic [1:0] REG_WINDOW      = 2'd1;
   localparam logic [1:0] REG_SPEED_GAIN  = 2'd2;
   localparam logic [1:0] REG_SPEED_LIMIT = 2'd3;

   localparam logic signed [AngW-1:0] ANG_PI      = 19'sd25736;
   localparam logic signed [AngW-1:0] ANG_HALF_PI = 19'sd12868;
   localparam logic signed [AngW-1:0] ANG_TWO_PI  = 19'sd51472;
   localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_SCAN, ST_PICK_RD, ST_PICK, ST_PREP, ST_CORDIC,
      ST_MAG, ST_ERR, ST_RATE, ST_SPEED, ST_OUT
   } state_type;

   // cordic unit control
   typedef struct packed {
      logic load;
      logic step;
   } cordic_ctl_type;

   function automatic logic signed [AngW-1:0] atan_q13(input logic [StepW-1:0] i);
      case (i)
         0: atan_q13 = 19'sd6434;
         1: atan_q13 = 19'sd3798;
         2: atan_q13 = 19'sd2007;
         3: atan_q13 = 19'sd1019;
         4: atan_q13 = 19'sd511;
         5: atan_q13 = 19'sd256;
         6: atan_q13 = 19'sd128;
         7: atan_q13 = 19'sd64;
         8: atan_q13 = 19'sd32;
         9: atan_q13 = 19'sd16;
         10: atan_q13 = 19'sd8;
         11: atan_q13 = 19'sd4;
         12: atan_q13 = 19'sd2;
         13: atan_q13 = 19'sd1;
         default: atan_q13 = '0;
      endcase
   endfunction
endpackage

@@ hdl/ntp_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module ntp_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ hdl/ntp_cordic.sv @@
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
// Depends on ntp_pkg.
`timescale 1ns / 1ps
module ntp_cordic import ntp_pkg::*; (
   input  logic                     clock,
   input  cordic_ctl_type           ctl,
   input  logic signed [16:0]       dx,
   input  logic signed [16:0]       dy,
   input  logic [StepW-1:0]         step,
   output logic signed [WorkW-1:0]  x_out,
   output logic signed [AngW-1:0]   z_out
);
   logic signed [WorkW-1:0] x_ff, x_in, y_ff, y_in, x0, y0, xs, ys;
   logic signed [AngW-1:0]  z_ff, z_in;
   always_comb begin
      x0 = WorkW'(dx) <<< 12;
      y0 = WorkW'(dy) <<< 12;
      xs = x_ff >>> step;
      ys = y_ff >>> step;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      if (ctl.load) begin
         if (x0 < 0 && y0 >= 0) begin
            x_in = y0; y_in = -x0; z_in = ANG_HALF_PI;
         end else if (x0 < 0) begin
            x_in = -y0; y_in = x0; z_in = -ANG_HALF_PI;
         end else begin
            x_in = x0; y_in = y0; z_in = '0;
         end
      end else if (ctl.step) begin
         if (y_ff >= 0) begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + atan_q13(step);
         end else begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - atan_q13(step);
         end
      end
   end
   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
   end
   assign x_out = x_ff;
   assign z_out = z_ff;
endmodule

@@ hdl/nearest_target_pursuit_controller_top.sv @@
// Top level of the nearest-target pursuit controller.
// Depends on ntp_pkg, ntp_ram, ntp_cordic and the defines header.
//
// Requests enter on req_ (valid/ready); op selects clear, append or pose.
// Clear and append act when accepted and give no response. A pose request
// gives one response on rsp_ (valid/ready) carrying forward_speed,
// turn_rate, chosen_id and chasing.
// A pose scans the table with one table read per entry: a lookup pass for
// the held id when one is held and, when it is absent, a nearest pass over
// the stored targets. Then the CORDIC unit runs CordicSteps micro-rotations,
// followed by magnitude, heading error (wrapped by two pi at a time), turn
// rate and speed. An empty table answers with zero outputs and chasing low.
// One request is in work at a time; req_ready is low while busy or
// while a response waits. A stalled receiver holds the response in its
// register; the next request is taken the cycle after it is delivered.
// Configuration writes on csr_ are always accepted, index 0..3; a write
// during reset is dropped. Reset empties the table, clears the held selection
// and loads default gains; table memory is not cleared and needs no sweep.
`timescale 1ns / 1ps
`include "nearest_target_pursuit_controller_top_defines.svh"
module nearest_target_pursuit_controller_top import ntp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_target_id,
   input  logic signed [15:0] req_target_x,
   input  logic signed [15:0] req_target_y,
   input  logic signed [15:0] req_pose_x,
   input  logic signed [15:0] req_pose_y,
   input  logic signed [15:0] req_pose_heading,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [14:0] rsp_forward_speed,
   output logic signed [15:0] rsp_turn_rate,
   output logic [7:0]  rsp_chosen_id,
   output logic        rsp_chasing,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   state_type state_ff, state_in;
   logic [11:0] turn_gain_ff, speed_gain_ff;
   logic [14:0] window_ff, limit_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic [7:0] held_id_ff, held_id_in;
   logic held_valid_ff, held_valid_in;
   logic [IdxW-1:0] idx_ff, idx_in, sel_ff, sel_in, rd_addr;
   logic [CntW-1:0] scan_ff, scan_in;
   logic lookup_ff, lookup_in, first_ff, first_in;
   logic [34:0] best_ff, best_in;
   logic signed [15:0] px_ff, py_ff, hd_ff;
   logic [StepW-1:0] step_ff, step_in;
   logic signed [AngW-1:0] err_ff, err_in;
   logic [16:0] dist_ff, dist_in;
   logic signed [31:0] prod_ff, prod_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [14:0] spd_ff, spd_in;
   logic signed [15:0] rate_ff, rate_in;
   logic [7:0] cid_ff, cid_in;
   logic chasing_ff, chasing_in;
   logic wr_en;
   logic [7:0] rd_id;
   logic signed [15:0] rd_x, rd_y;
   logic signed [16:0] ex, ey;
   logic [34:0] d2;
   logic [48:0] mag_prod;
   logic signed [AngW-1:0] z_out, e0;
   logic signed [WorkW-1:0] x_out;
   logic [WorkW-2:0] xpos;
   logic signed [33:0] rate_w;
   logic [AngW-1:0] abs_err;
   logic [29:0] spd_w;
   cordic_ctl_type cctl;
   logic accept;

   assign accept = req_valid && req_ready;
   assign wr_en = accept && req_op == OP_APPEND && count_ff < CntW'(MaxTargets);
   assign csr_ready = 1'b1;

   ntp_ram #(.Width(8), .Depth(MaxTargets)) u_id (.clock, .wr_en,
      .wr_addr(count_ff[IdxW-1:0]), .wr_data(req_target_id), .rd_addr, .rd_data(rd_id));
   ntp_ram #(.Width(16), .Depth(MaxTargets)) u_x (.clock, .wr_en,
      .wr_addr(count_ff[IdxW-1:0]), .wr_data(req_target_x), .rd_addr, .rd_data(rd_x));
   ntp_ram #(.Width(16), .Depth(MaxTargets)) u_y (.clock, .wr_en,
      .wr_addr(count_ff[IdxW-1:0]), .wr_data(req_target_y), .rd_addr, .rd_data(rd_y));

   ntp_cordic u_cordic (.clock, .ctl(cctl), .dx(ex), .dy(ey), .step(step_ff),
      .x_out, .z_out);

   always_comb begin
      ex = 17'(rd_x) - 17'(px_ff);
      ey = 17'(rd_y) - 17'(py_ff);
      d2 = 35'($signed(ex) * $signed(ex)) + 35'($signed(ey) * $signed(ey));
      xpos = x_out < 0 ? '0 : x_out[WorkW-2:0];
      mag_prod = 49'(xpos) * 49'(INV_GAIN_Q16) + (49'(1) << 27);
      e0 = z_out - 19'(hd_ff);
      rate_w = (34'(prod_ff) + 34'sd512) >>> 10;
      abs_err = err_ff < 0 ? 19'(-err_ff) : 19'(err_ff);
      spd_w = 30'(prod_ff) + 30'd128;
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; held_id_in = held_id_ff;
      held_valid_in = held_valid_ff; idx_in = idx_ff; sel_in = sel_ff;
      scan_in = scan_ff; lookup_in = lookup_ff; first_in = first_ff;
      best_in = best_ff; step_in = step_ff; err_in = err_ff; dist_in = dist_ff;
      prod_in = prod_ff; rsp_valid_in = rsp_valid_ff && !rsp_ready;
      spd_in = spd_ff; rate_in = rate_ff; cid_in = cid_ff; chasing_in = chasing_ff;
      cctl = '0; rd_addr = idx_ff;
      req_ready = state_ff == ST_IDLE && !rsp_valid_ff;
      case (state_ff)
         ST_IDLE: if (accept) begin
            case (req_op)
               OP_CLEAR: count_in = '0;
               OP_APPEND: if (wr_en) count_in = count_ff + 1'b1;
               OP_POSE: begin
                  if (count_ff == '0) begin
                     held_valid_in = 1'b0;
                     spd_in = '0; rate_in = '0; cid_in = '0; chasing_in = 1'b0;
                     state_in = ST_OUT;
                  end else begin
                     idx_in = '0; scan_in = '0; first_in = 1'b1;
                     lookup_in = held_valid_ff;
                     rd_addr = '0;
                     state_in = ST_RD;
                  end
               end
               default: ;
            endcase
         end
         ST_RD: begin
            // read data for scan_ff arrives next cycle
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (lookup_ff) begin
               if (rd_id == held_id_ff) begin
                  sel_in = scan_ff[IdxW-1:0];
                  state_in = ST_PICK_RD;
               end
            end else if (first_ff || d2 < best_ff) begin
               best_in = d2; sel_in = scan_ff[IdxW-1:0]; first_in = 1'b0;
            end
            if (!(lookup_ff && rd_id == held_id_ff)) begin
               if (scan_ff + 1'b1 >= count_ff) begin
                  scan_in = '0; idx_in = '0;
                  if (lookup_ff) begin
                     lookup_in = 1'b0; first_in = 1'b1;
                     state_in = ST_RD;
                  end else begin
                     state_in = ST_PICK_RD;
                  end
               end else begin
                  scan_in = scan_ff + 1'b1;
                  idx_in = IdxW'(scan_ff + 1'b1);
                  state_in = ST_RD;
               end
            end
            rd_addr = idx_in;
         end
         ST_PICK_RD: begin
            rd_addr = sel_ff;
            idx_in = sel_ff;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            held_id_in = rd_id; held_valid_in = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cctl.load = 1'b1; step_in = '0;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            cctl.step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == StepW'(CordicSteps - 1)) state_in = ST_MAG;
         end
         ST_MAG: begin
            dist_in = (ex == 0 && ey == 0) ? '0 : 17'(mag_prod >> 28);
            err_in = (ex == 0 && ey == 0) ? -19'(hd_ff) : e0;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            if (err_ff > ANG_PI) err_in = err_ff - ANG_TWO_PI;
            else if (err_ff < -ANG_PI) err_in = err_ff + ANG_TWO_PI;
            else begin
               prod_in = 32'($signed({1'b0, turn_gain_ff}) * err_ff);
               state_in = ST_RATE;
            end
         end
         ST_RATE: begin
            if (rate_w > 34'sd32767) rate_in = 16'sd32767;
            else if (rate_w < -34'sd32768) rate_in = -16'sd32768;
            else rate_in = 16'(rate_w);
            prod_in = 32'(speed_gain_ff) * 32'(dist_ff);
            state_in = ST_SPEED;
         end
         ST_SPEED: begin
            spd_in = '0;
            if (abs_err < 19'(window_ff))
               spd_in = (spd_w >> 8) > 30'(limit_ff) ? limit_ff : 15'(spd_w >> 8);
            cid_in = held_id_ff; chasing_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; held_id_ff <= '0;
         held_valid_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         turn_gain_ff <= 12'd1024; window_ff <= 15'd4096;
         speed_gain_ff <= 12'd384; limit_ff <= 15'd4096;
      end else begin
         state_ff <= state_in; count_ff <= count_in; held_id_ff <= held_id_in;
         held_valid_ff <= held_valid_in; rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               REG_TURN_GAIN:   turn_gain_ff <= csr_data[11:0];
               REG_WINDOW:      window_ff <= csr_data[14:0];
               REG_SPEED_GAIN:  speed_gain_ff <= csr_data[11:0];
               REG_SPEED_LIMIT: limit_ff <= csr_data[14:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; sel_ff <= sel_in; scan_ff <= scan_in; lookup_ff <= lookup_in;
      first_ff <= first_in; best_ff <= best_in; step_ff <= step_in; err_ff <= err_in;
      dist_ff <= dist_in; prod_ff <= prod_in; spd_ff <= spd_in; rate_ff <= rate_in;
      cid_ff <= cid_in; chasing_ff <= chasing_in;
      if (accept) begin
         px_ff <= req_pose_x; py_ff <= req_pose_y; hd_ff <= req_pose_heading;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_forward_speed = spd_ff;
   assign rsp_turn_rate = rate_ff;
   assign rsp_chosen_id = cid_ff;
   assign rsp_chasing = chasing_ff;

   `NTP_ASSERT_IMP(a_count_max, 1'b1, count_ff <= CntW'(MaxTargets), "table count overflow")
   `NTP_ASSERT_IMP(a_busy_ready, state_ff != ST_IDLE, !req_ready, "ready while busy")
   `NTP_ASSERT_NEXT(a_out_valid, state_ff == ST_OUT, rsp_valid, "response not raised")
   `NTP_ASSERT_IMP(a_chase_held, rsp_valid && rsp_chasing, held_valid_ff, "no selection")
endmodule

@@ tb/sv/ntp_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the pursuit controller: tracks the target table, the held
// selection and the gains, predicts each pose response and compares it.
// Depends on ntp_pkg.
module ntp_checker import ntp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [7:0]         req_target_id,
   input  logic signed [15:0] req_target_x,
   input  logic signed [15:0] req_target_y,
   input  logic signed [15:0] req_pose_x,
   input  logic signed [15:0] req_pose_y,
   input  logic signed [15:0] req_pose_heading,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [14:0]        rsp_forward_speed,
   input  logic signed [15:0] rsp_turn_rate,
   input  logic [7:0]         rsp_chosen_id,
   input  logic               rsp_chasing,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 errors,
   output int                 outstanding
);
   typedef struct packed {
      logic [14:0]        speed;
      logic signed [15:0] rate;
      logic [7:0]         id;
      logic               chasing;
   } command_type;

   logic signed [15:0] tgt_x [MaxTargets];
   logic signed [15:0] tgt_y [MaxTargets];
   logic [7:0]         tgt_id [MaxTargets];
   int                 tgt_count;
   logic [7:0]         held_id;
   logic               held_valid;
   logic [11:0]        turn_gain, speed_gain;
   logic [14:0]        window, speed_limit;
   command_type        pending_cmds [$];

   function automatic command_type pursue(input longint px, input longint py,
                                          input longint hd);
      command_type c;
      longint ex, ey, d2, best, x, y, z, t, range_q, err, rate, spd;
      longint atan_tab [14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
      int sel;
      bit found;
      c = '0;
      sel = 0;
      found = 0;
      if (tgt_count == 0) begin
         held_valid = 0;
         return c;
      end
      if (held_valid)
         for (int i = 0; i < tgt_count; i++)
            if (!found && tgt_id[i] == held_id) begin
               sel = i;
               found = 1;
            end
      if (!found) begin
         best = 0;
         for (int i = 0; i < tgt_count; i++) begin
            ex = longint'(tgt_x[i]) - px;
            ey = longint'(tgt_y[i]) - py;
            d2 = ex * ex + ey * ey;
            if (i == 0 || d2 < best) begin
               best = d2;
               sel = i;
            end
         end
         held_id = tgt_id[sel];
         held_valid = 1;
      end
      ex = longint'(tgt_x[sel]) - px;
      ey = longint'(tgt_y[sel]) - py;
      range_q = 0;
      z = 0;
      if (ex != 0 || ey != 0) begin
         x = ex <<< 12;
         y = ey <<< 12;
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y; y = -t; z = 12868;
            end else begin
               x = -y; y = t; z = -12868;
            end
         end
         for (int i = 0; i < CordicSteps; i++) begin
            t = x;
            if (y >= 0) begin
               x += y >>> i; y -= t >>> i; z += (i < 14) ? atan_tab[i] : 0;
            end else begin
               x -= y >>> i; y += t >>> i; z -= (i < 14) ? atan_tab[i] : 0;
            end
         end
         if (x < 0) x = 0;
         range_q = (x * 39797 + (longint'(1) << 27)) >>> 28;
      end
      err = z - hd;
      while (err > 25736) err -= 51472;
      while (err < -25736) err += 51472;
      rate = (longint'(turn_gain) * err + 512) >>> 10;
      if (rate > 32767) rate = 32767;
      if (rate < -32768) rate = -32768;
      spd = 0;
      if ((err < 0 ? -err : err) < longint'(window)) begin
         spd = (longint'(speed_gain) * range_q + 128) >>> 8;
         if (spd > longint'(speed_limit)) spd = longint'(speed_limit);
      end
      c.speed = spd[14:0];
      c.rate = rate[15:0];
      c.id = held_id;
      c.chasing = 1;
      return c;
   endfunction

   always @(posedge clock) begin
      command_type want;
      if (reset) begin
         tgt_count = 0;
         held_id = 0;
         held_valid = 0;
         turn_gain = 1024;
         window = 4096;
         speed_gain = 384;
         speed_limit = 4096;
         pending_cmds.delete();
         errors <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_cmds.size() == 0) begin
               $display("%0t: response with none expected: speed %0d rate %0d id %0d chasing %0d",
                        $time, rsp_forward_speed, rsp_turn_rate, rsp_chosen_id, rsp_chasing);
               errors <= errors + 1;
            end else begin
               want = pending_cmds.pop_front();
               if (want.speed !== rsp_forward_speed || want.rate !== rsp_turn_rate ||
                   want.id !== rsp_chosen_id || want.chasing !== rsp_chasing) begin
                  $display("%0t: mismatch expected speed %0d rate %0d id %0d chasing %0d",
                           $time, want.speed, want.rate, want.id, want.chasing);
                  $display("%0t:          actual   speed %0d rate %0d id %0d chasing %0d",
                           $time, rsp_forward_speed, rsp_turn_rate, rsp_chosen_id,
                           rsp_chasing);
                  errors <= errors + 1;
               end
            end
         end
         if (csr_valid && csr_ready)
            case (csr_index)
               REG_TURN_GAIN:   turn_gain = csr_data[11:0];
               REG_WINDOW:      window = csr_data[14:0];
               REG_SPEED_GAIN:  speed_gain = csr_data[11:0];
               REG_SPEED_LIMIT: speed_limit = csr_data[14:0];
               default: ;
            endcase
         if (req_valid && req_ready)
            case (req_op)
               OP_CLEAR: tgt_count = 0;
               OP_APPEND:
                  if (tgt_count < MaxTargets) begin
                     tgt_id[tgt_count] = req_target_id;
                     tgt_x[tgt_count] = req_target_x;
                     tgt_y[tgt_count] = req_target_y;
                     tgt_count++;
                  end
               OP_POSE:
                  pending_cmds.push_back(pursue(longint'(req_pose_x), longint'(req_pose_y),
                                                longint'(req_pose_heading)));
               default: ;
            endcase
         outstanding <= pending_cmds.size();
      end
   end
endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the pursuit controller: clock, reset, request and
// register stimulus, response back-pressure and verdict.
// Depends on ntp_pkg, ntp_checker and the controller RTL.
module tb_top;
   import ntp_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 5000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready;
   logic [1:0] req_op = OP_CLEAR;
   logic [7:0] req_target_id = 0;
   logic signed [15:0] req_target_x = 0, req_target_y = 0;
   logic signed [15:0] req_pose_x = 0, req_pose_y = 0, req_pose_heading = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [14:0] rsp_forward_speed;
   logic signed [15:0] rsp_turn_rate;
   logic [7:0] rsp_chosen_id;
   logic rsp_chasing;
   logic csr_valid = 0, csr_ready;
   logic [1:0] csr_index = REG_TURN_GAIN;
   logic [15:0] csr_data = 0;
   int errors, outstanding;
   bit idle_on = 1;
   int rsp_hold = 0, quiet_cycles = 0;
   int n_pose = 0, n_append = 0, n_csr = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   nearest_target_pursuit_controller_top uut (.*);
   ntp_checker chk (.*);

   always @(posedge clock) begin
      int nxt;
      nxt = rsp_hold;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) nxt = idle_on ? $urandom_range(0, 5) : 0;
         else if (nxt > 0) nxt--;
         rsp_ready <= (nxt == 0);
      end
      rsp_hold <= nxt;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [7:0] rnd8();
      return 8'($urandom);
   endfunction

   function automatic logic signed [15:0] rnd16();
      return 16'($urandom);
   endfunction

   function automatic logic signed [15:0] coord();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 8191) - 4096);
         2: return 16'($urandom_range(0, 1023) - 512);
         default: return 16'($urandom_range(0, 32767) - 16384);
      endcase
   endfunction

   task automatic send(input logic [1:0] op, input logic [7:0] id,
                       input logic signed [15:0] tx, ty, px, py, hd);
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_target_id <= id;
      req_target_x <= tx;
      req_target_y <= ty;
      req_pose_x <= px;
      req_pose_y <= py;
      req_pose_heading <= hd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_POSE) n_pose++;
      if (op == OP_APPEND) n_append++;
   endtask

   task automatic append(input logic [7:0] id, input logic signed [15:0] tx, ty);
      send(OP_APPEND, id, tx, ty, rnd16(), rnd16(), rnd16());
   endtask

   task automatic pose(input logic signed [15:0] px, py, hd);
      send(OP_POSE, rnd8(), rnd16(), rnd16(), px, py, hd);
   endtask

   task automatic drain();
      req_valid <= 0;
      do @(posedge clock); while (outstanding != 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
      n_csr++;
   endtask

   task automatic set_gains(input logic [15:0] tg, win, sg, lim);
      write_reg(REG_TURN_GAIN, tg);
      write_reg(REG_WINDOW, win);
      write_reg(REG_SPEED_GAIN, sg);
      write_reg(REG_SPEED_LIMIT, lim);
   endtask

   initial begin
      int ntgt, nposes, sent;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      pose(16'sd0, 16'sd0, 16'sd0);
      append(8'd0, 16'sh8000, 16'sh8000);
      append(8'd255, 16'sd32767, 16'sd32767);
      pose(16'sd32767, 16'sd32767, 16'sd32767);
      pose(16'sh8000, 16'sh8000, 16'sh8000);
      pose(16'sd32767, 16'sh8000, 16'sd25736);
      send(OP_UNUSED, 8'hAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
      send(OP_CLEAR, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      pose(16'sd100, 16'sd100, 16'sd0);
      for (int i = 0; i < MaxTargets + 2; i++) append(8'd7, 16'(i * 300), 16'(-i * 200));
      pose(16'sd0, 16'sd0, -16'sd25736);
      pose(16'sd1500, -16'sd1000, 16'sd0);
      drain();
      set_gains(16'd0, 16'd0, 16'd0, 16'd0);
      pose(-16'sd500, 16'sd700, 16'sd100);
      drain();
      set_gains(16'd4095, 16'd25736, 16'd4095, 16'd32767);
      pose(16'sd4000, 16'sd4000, 16'sd0);
      pose(-16'sd4000, 16'sd1000, -16'sd3000);
      drain();

      sent = 0;
      while (sent < 1400) begin
         idle_on = (($urandom_range(0, 3)) != 0);
         case ($urandom_range(0, 4))
            0: set_gains(16'd1024, 16'd4096, 16'd384, 16'd4096);
            1: set_gains(16'd4095, 16'd25736, 16'd4095, 16'd32767);
            2: set_gains(16'd0, 16'($urandom_range(0, 25736)), 16'd0,
                         16'($urandom_range(0, 32767)));
            3: set_gains(rnd16(), rnd16(), rnd16(), rnd16());
            default: set_gains(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 25736)),
                               16'($urandom_range(0, 4095)), 16'($urandom_range(0, 32767)));
         endcase
         for (int s = 0; s < 12 && sent < 1400; s++) begin
            send(OP_CLEAR, rnd8(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
            ntgt = ($urandom_range(0, 9) == 0) ? $urandom_range(MaxTargets, MaxTargets + 3)
                                               : $urandom_range(1, 5);
            for (int k = 0; k < ntgt; k++)
               append(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : rnd8(),
                      coord(), coord());
            nposes = $urandom_range(1, 8);
            for (int k = 0; k < nposes; k++)
               case ($urandom_range(0, 9))
                  0: send(OP_UNUSED, rnd8(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
                  1: append(rnd8(), coord(), coord());
                  2: pose(coord(), coord(), rnd16());
                  default: pose(coord(), coord(), 16'($urandom_range(0, 51472) - 25736));
               endcase
            if ($urandom_range(0, 9) == 0) pose(coord(), coord(), rnd16());
            sent += ntgt + nposes + 1;
            if ($urandom_range(0, 15) == 0) begin
               req_valid <= 0;
               do @(posedge clock); while (outstanding != 0);
            end
         end
         drain();
      end

      $display("covered %0d pose and %0d append requests, %0d register writes",
               n_pose, n_append, n_csr);
      $display("including empty and overflowing tables, duplicate ids and gain extremes");
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
